// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never be true.
`define ASSERT_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition seen");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/cctok_pkg.sv =====
// ----------------------------------------------------------------------------
// cctok_pkg
// Types, codes and tables shared by the character class word tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cctok_pkg;

	localparam int POS_W       = 16;
	localparam int QDEPTH      = 4;
	localparam int QADDR_W     = $clog2(QDEPTH);
	localparam int QCNT_W      = QADDR_W + 1;
	localparam int NUM_STATES  = 4;
	localparam int NUM_CLASSES = 4;
	localparam int NUM_RES     = 4;

	localparam logic [7:0] CH_TAB        = 8'd9;
	localparam logic [7:0] CH_SPACE      = 8'd32;
	localparam logic [7:0] CH_ZERO       = 8'd48;
	localparam logic [7:0] CH_NINE       = 8'd57;
	localparam logic [7:0] CH_SEMI       = 8'd59;
	localparam logic [7:0] CH_UPPER_A    = 8'd65;
	localparam logic [7:0] CH_UPPER_Z    = 8'd90;
	localparam logic [7:0] CH_UNDERSCORE = 8'd95;
	localparam logic [7:0] CH_LOWER_A    = 8'd97;
	localparam logic [7:0] CH_LOWER_Z    = 8'd122;

	localparam logic RK_SPAN      = 1'b0;
	localparam logic RK_BLOCK_END = 1'b1;

	// result slots of one job, in output order
	localparam int RES_EMIT     = 0;
	localparam int RES_SEMI     = 1;
	localparam int RES_FIN_SPAN = 2;
	localparam int RES_FIN_END  = 3;

	typedef enum logic [1:0] {
		ST_BLANK = 2'd0,
		ST_ALPHA = 2'd1,
		ST_OTHER = 2'd2,
		ST_DIGIT = 2'd3
	} scan_state_t;

	typedef enum logic [1:0] {
		CL_OTHER = 2'd0,
		CL_BLANK = 2'd1,
		CL_ALPHA = 2'd2,
		CL_DIGIT = 2'd3
	} char_class_t;

	typedef enum logic [1:0] {
		FX_NONE = 2'd0,
		FX_EMIT = 2'd1,
		FX_MARK = 2'd2
	} effect_t;

	typedef struct packed {
		effect_t     fx;
		scan_state_t nxt;
	} step_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic             record_kind;
		logic [POS_W-1:0] span_begin;
		logic [POS_W-1:0] span_end;
		logic             last_of_run;
	} out_item_t;

	typedef struct packed {
		logic             emit;
		logic [POS_W-1:0] emit_begin;
		logic [POS_W-1:0] emit_end;
		logic             semi;
		logic             fin;
		logic [POS_W-1:0] fin_begin;
		logic [POS_W-1:0] fin_end;
	} job_t;

	localparam step_t STEP_TABLE [NUM_STATES][NUM_CLASSES] = '{
		'{'{FX_MARK, ST_BLANK}, '{FX_NONE, ST_BLANK}, '{FX_MARK, ST_ALPHA}, '{FX_MARK, ST_DIGIT}},
		'{'{FX_EMIT, ST_OTHER}, '{FX_EMIT, ST_BLANK}, '{FX_NONE, ST_ALPHA}, '{FX_EMIT, ST_DIGIT}},
		'{'{FX_NONE, ST_OTHER}, '{FX_EMIT, ST_BLANK}, '{FX_EMIT, ST_ALPHA}, '{FX_EMIT, ST_DIGIT}},
		'{'{FX_EMIT, ST_OTHER}, '{FX_EMIT, ST_BLANK}, '{FX_EMIT, ST_ALPHA}, '{FX_NONE, ST_DIGIT}}
	};

	function automatic char_class_t classify(logic [7:0] c);
		char_class_t cl;
		cl = CL_OTHER;
		if (c == CH_TAB || c == CH_SPACE) begin
			cl = CL_BLANK;
		end else if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_UNDERSCORE) begin
			cl = CL_DIGIT;
		end else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
		             (c >= CH_LOWER_A && c <= CH_LOWER_Z)) begin
			cl = CL_ALPHA;
		end
		return cl;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cctok_front.sv =====
// ----------------------------------------------------------------------------
// cctok_front
// Accepts characters, classifies them, steps the scan state and, for a
// character that causes results, queues a job describing them.
// ----------------------------------------------------------------------------
`default_nettype none

module cctok_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cctok_pkg::in_item_t in_data,
	input  wire logic               q_full,
	output logic                    q_push,
	output cctok_pkg::job_t         q_job
);
	import cctok_pkg::*;

	scan_state_t      scan_q;
	logic [POS_W-1:0] begin_q;
	logic [POS_W-1:0] pos_q;

	char_class_t      cls;
	step_t            step;
	logic             accept;
	logic             is_semi;
	logic             emit;
	logic [POS_W-1:0] begin_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign cls      = classify(in_data.char_code);
	assign step     = STEP_TABLE[scan_q][cls];
	assign is_semi  = (in_data.char_code == CH_SEMI);
	assign emit     = (step.fx == FX_EMIT);

	always_comb begin
		unique case (step.fx)
			FX_EMIT, FX_MARK: begin
				begin_next = pos_q;
			end
			default: begin
				begin_next = begin_q;
			end
		endcase
	end

	always_comb begin
		q_job.emit       = emit;
		q_job.emit_begin = begin_q;
		q_job.emit_end   = pos_q - POS_W'(1);
		q_job.semi       = is_semi;
		q_job.fin        = in_data.end_of_string && !is_semi;
		q_job.fin_begin  = begin_next;
		q_job.fin_end    = pos_q;
	end

	assign q_push = accept && (emit || is_semi || in_data.end_of_string);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= ST_BLANK;
			begin_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			if (in_data.end_of_string) begin
				scan_q  <= ST_BLANK;
				begin_q <= '0;
				pos_q   <= '0;
			end else begin
				scan_q  <= step.nxt;
				begin_q <= begin_next;
				pos_q   <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cctok_fifo.sv =====
// ----------------------------------------------------------------------------
// cctok_fifo
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cctok_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire cctok_pkg::job_t wr_job,
	input  wire logic            pop,
	output cctok_pkg::job_t      head,
	output logic                 full,
	output logic                 empty
);
	import cctok_pkg::*;

	job_t               mem_q [QDEPTH];
	logic [QADDR_W-1:0] wr_ptr_q;
	logic [QADDR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QADDR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QADDR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full)
	`ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty)
	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > QCNT_W'(QDEPTH))

endmodule

`default_nettype wire

// ===== hw/rtl/cctok_back.sv =====
// ----------------------------------------------------------------------------
// cctok_back
// Walks the job at the queue head and sends its results one per cycle
// through the output register while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cctok_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_empty,
	input  wire cctok_pkg::job_t q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output cctok_pkg::out_item_t out_data
);
	import cctok_pkg::*;

	logic [NUM_RES-1:0] sent_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [NUM_RES-1:0] need;
	logic [NUM_RES-1:0] remaining;
	logic [NUM_RES-1:0] pick;
	logic               last;
	logic               load;
	logic               take;
	out_item_t          res;

	always_comb begin
		need               = '0;
		need[RES_EMIT]     = q_head.emit;
		need[RES_SEMI]     = q_head.semi;
		need[RES_FIN_SPAN] = q_head.fin;
		need[RES_FIN_END]  = q_head.fin;
	end

	assign remaining = need & ~sent_q;
	assign pick      = remaining & (~remaining + NUM_RES'(1));
	assign last      = ((remaining & ~pick) == '0);
	assign load      = !out_valid_q || out_ready;
	assign take      = load && !q_empty;
	assign q_pop     = take && last;

	always_comb begin
		res.record_kind = RK_BLOCK_END;
		res.span_begin  = '0;
		res.span_end    = '0;
		res.last_of_run = last;
		priority if (remaining[RES_EMIT]) begin
			res.record_kind = RK_SPAN;
			res.span_begin  = q_head.emit_begin;
			res.span_end    = q_head.emit_end;
		end else if (remaining[RES_SEMI]) begin
			res.record_kind = RK_BLOCK_END;
		end else if (remaining[RES_FIN_SPAN]) begin
			res.record_kind = RK_SPAN;
			res.span_begin  = q_head.fin_begin;
			res.span_end    = q_head.fin_end;
		end else begin
			res.record_kind = RK_BLOCK_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sent_q      <= '0;
		end else if (take) begin
			out_valid_q <= 1'b1;
			sent_q      <= last ? '0 : (sent_q | pick);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_IMPLIES(a_take_has_work, clk, arst_n, take, remaining != '0)
	`ASSERT_IMPLIES(a_sent_in_need, clk, arst_n, !q_empty, (sent_q & ~need) == '0)
	`ASSERT_NEXT(a_partial_holds, clk, arst_n, take && !last, sent_q != '0 && !q_empty)

endmodule

`default_nettype wire

// ===== hw/rtl/char_class_word_tokenizer.sv =====
// ----------------------------------------------------------------------------
// char_class_word_tokenizer
// Table-driven word tokenizer: classifies one character per transaction and
// emits token spans and block-end records.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one character per transaction (char_code, end_of_string).
//   out_* : result records (record_kind, span_begin, span_end, last_of_run);
//           a character yields zero to three records, the last one flagged.
//   Records pass through the job queue, then the output register. The
//   front takes one character per cycle while the queue is not full; the
//   back sends one record per cycle while out_ready is high, so a character
//   with several records holds the output longer. A four-entry job queue
//   absorbs the difference; characters with no record never enter it.
//   in_ready drops only while the job queue is full, which happens when the
//   receiver stalls out_ready or records arrive faster than one per cycle.
//   The output register keeps its record while out_ready is low.
//   Reset clears scan state, token begin, position, queue and output valid;
//   the block accepts characters as soon as reset is released.
//   After an end-of-string character the scan state returns to its reset
//   value.
// ----------------------------------------------------------------------------
`default_nettype none

module char_class_word_tokenizer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire cctok_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output cctok_pkg::out_item_t      out_data
);
	import cctok_pkg::*;

	job_t wr_job;
	job_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	cctok_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (full),
		.q_push   (push),
		.q_job    (wr_job)
	);

	cctok_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	cctok_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_head    (head),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== dv/cctok_record_checker.sv =====
// ----------------------------------------------------------------------------
// cctok_record_checker
// Watches both channels of the character class word tokenizer, predicts the
// span and block-end records of every accepted character and compares each
// accepted record field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module cctok_record_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire cctok_pkg::in_item_t  in_data,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire cctok_pkg::out_item_t out_data,
	input  wire logic                 drain_done,
	output int unsigned               pending,
	output int unsigned               errors
);
	import cctok_pkg::*;

	typedef struct packed {
		effect_t     fx;
		scan_state_t nxt;
	} move_t;

	localparam move_t MOVES [4][4] = '{
		'{'{FX_MARK, ST_BLANK}, '{FX_NONE, ST_BLANK}, '{FX_MARK, ST_ALPHA}, '{FX_MARK, ST_DIGIT}},
		'{'{FX_EMIT, ST_OTHER}, '{FX_EMIT, ST_BLANK}, '{FX_NONE, ST_ALPHA}, '{FX_EMIT, ST_DIGIT}},
		'{'{FX_NONE, ST_OTHER}, '{FX_EMIT, ST_BLANK}, '{FX_EMIT, ST_ALPHA}, '{FX_EMIT, ST_DIGIT}},
		'{'{FX_EMIT, ST_OTHER}, '{FX_EMIT, ST_BLANK}, '{FX_EMIT, ST_ALPHA}, '{FX_NONE, ST_DIGIT}}
	};

	scan_state_t      scan_st;
	logic [POS_W-1:0] tok_begin;
	logic [POS_W-1:0] char_pos;
	out_item_t        expected_records [$];

	initial errors = 0;
	initial pending = 0;

	function automatic char_class_t class_of(logic [7:0] c);
		if (c == 8'd9 || c == 8'd32)
			return CL_BLANK;
		if ((c >= 8'd48 && c <= 8'd57) || c == 8'd95)
			return CL_DIGIT;
		if ((c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122))
			return CL_ALPHA;
		return CL_OTHER;
	endfunction

	function automatic out_item_t make_record(logic kind, logic [POS_W-1:0] b,
	                                          logic [POS_W-1:0] e);
		out_item_t r;
		r.record_kind = kind;
		r.span_begin  = b;
		r.span_end    = e;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	task automatic predict_records(input in_item_t it);
		out_item_t        recs [$];
		move_t            mv;
		logic [POS_W-1:0] prev;
		logic             semi;
		prev = char_pos - 1'b1;
		semi = (it.char_code == CH_SEMI);
		mv = MOVES[scan_st][class_of(it.char_code)];
		scan_st = mv.nxt;
		if (mv.fx == FX_EMIT) begin
			recs.push_back(make_record(RK_SPAN, tok_begin, prev));
			tok_begin = char_pos;
		end else if (mv.fx == FX_MARK) begin
			tok_begin = char_pos;
		end
		if (semi)
			recs.push_back(make_record(RK_BLOCK_END, '0, '0));
		if (it.end_of_string) begin
			if (!semi) begin
				recs.push_back(make_record(RK_SPAN, tok_begin, char_pos));
				recs.push_back(make_record(RK_BLOCK_END, '0, '0));
			end
			scan_st   = ST_BLANK;
			tok_begin = '0;
			char_pos  = '0;
		end else begin
			char_pos = char_pos + 1'b1;
		end
		if (recs.size() > 0)
			recs[recs.size()-1].last_of_run = 1'b1;
		foreach (recs[i])
			expected_records.push_back(recs[i]);
	endtask

	task automatic compare_record(input out_item_t got);
		out_item_t want;
		if (expected_records.size() == 0) begin
			report_mismatch($sformatf("unexpected record kind=%0d begin=%0d end=%0d last=%0d",
				got.record_kind, got.span_begin, got.span_end, got.last_of_run));
			return;
		end
		want = expected_records.pop_front();
		if (got.record_kind != want.record_kind)
			report_mismatch($sformatf("record_kind got %0d want %0d",
				got.record_kind, want.record_kind));
		if (got.span_begin != want.span_begin)
			report_mismatch($sformatf("span_begin got %0d want %0d",
				got.span_begin, want.span_begin));
		if (got.span_end != want.span_end)
			report_mismatch($sformatf("span_end got %0d want %0d",
				got.span_end, want.span_end));
		if (got.last_of_run != want.last_of_run)
			report_mismatch($sformatf("last_of_run got %0d want %0d",
				got.last_of_run, want.last_of_run));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_st   = ST_BLANK;
			tok_begin = '0;
			char_pos  = '0;
			expected_records.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				compare_record(out_data);
			if (in_valid && in_ready)
				predict_records(in_data);
			if (drain_done) begin
				foreach (expected_records[i])
					report_mismatch($sformatf("missing record kind=%0d begin=%0d end=%0d",
						expected_records[i].record_kind, expected_records[i].span_begin,
						expected_records[i].span_end));
				expected_records.delete();
			end
			pending <= expected_records.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_char_class_word_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_char_class_word_tokenizer
// Drives directed strings, random strings and noise into the tokenizer, with
// random idling on both sides, and reports the verdict from the record
// checker, or an error if traffic stalls beyond the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_char_class_word_tokenizer;
	import cctok_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int RANDOM_ITEMS = 335;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        quiet = 1'b0;
	logic        drain_done = 1'b0;
	int unsigned pending;
	int unsigned errors;
	int unsigned stall_cycles = 0;

	char_class_word_tokenizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	cctok_record_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.drain_done (drain_done),
		.pending    (pending),
		.errors     (errors)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 28);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_char();
		logic [7:0] c;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 30)
			c = $urandom_range(1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
		else if (roll < 50)
			c = ($urandom_range(4) == 0) ? CH_UNDERSCORE : 8'($urandom_range(48, 57));
		else if (roll < 68)
			c = $urandom_range(1) ? CH_TAB : CH_SPACE;
		else if (roll < 90) begin
			case ($urandom_range(3))
				0: c = 8'd39;
				1: c = 8'($urandom_range(128, 255));
				2: c = 8'($urandom_range(0, 8));
				default: c = 8'($urandom_range(33, 47));
			endcase
		end else
			c = CH_SEMI;
		return c;
	endfunction

	task automatic send_char(input logic [7:0] c, input logic eos);
		while (!quiet && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{char_code: c, end_of_string: eos};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	initial begin
		int unsigned sent;
		int unsigned len;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_text("Za_9 z;");
		send_text(" ");
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b0);
		send_char(8'h27, 1'b0);
		send_char(8'h7F, 1'b1);
		send_text("A\t'Q;R");

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			quiet <= (sent >= 150 && sent < 230);
			if ($urandom_range(99) < 80) begin
				len = $urandom_range(1, 12);
				for (int k = 0; k < len; k++)
					send_char(pick_char(), k == len - 1);
				sent += len;
			end else begin
				send_char(8'($urandom), $urandom_range(7) == 0);
				sent++;
			end
		end
		in_valid <= 1'b0;
		quiet    <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		drain_done <= 1'b1;
		@(posedge clk);
		drain_done <= 1'b0;
		repeat (2) @(posedge clk);

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
